[sv/sxfd_pkg.sv]
// shared types and constants of the sprite xor framebuffer draw unit
`default_nettype none

package sxfd_pkg;

   localparam int DEF_SCREEN_COLUMNS = 64;
   localparam int DEF_SCREEN_ROWS    = 32;
   localparam int ROW_BITS           = 64;
   localparam int SPRITE_W           = 8;
   localparam int POS_W              = $clog2(ROW_BITS);
   localparam int RECIP_SH           = 16;

   localparam logic KIND_DRAW = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] x_position;
      logic [7:0] y_position;
      logic [3:0] row_offset;
      logic [7:0] pixel_bits;
      logic       first_row;
      logic       last_row;
      logic [4:0] read_row;
   } sxfd_req_type;

   typedef struct packed {
      logic                collision;
      logic                sprite_done;
      logic [ROW_BITS-1:0] row_data;
   } sxfd_rsp_type;

endpackage

`default_nettype wire

[sv/sxfd_row_xor.sv]
// xor of one sprite byte into one framebuffer row word with collision detect
`default_nettype none

module sxfd_row_xor #(
   parameter int SCREEN_COLUMNS = sxfd_pkg::DEF_SCREEN_COLUMNS
) (
   input  logic [7:0]                    x_position,
   input  logic [7:0]                    pixel_bits,
   input  logic [sxfd_pkg::ROW_BITS-1:0] word_old,
   output logic [sxfd_pkg::ROW_BITS-1:0] word_new,
   output logic                          hit
);
   import sxfd_pkg::*;

   localparam int CW = $clog2(SCREEN_COLUMNS + SPRITE_W);
   localparam logic [16:0] COL_RECIP = 17'((1 << RECIP_SH) / SCREEN_COLUMNS);

   logic [24:0]         x_prod;
   logic [8:0]          x_quo;
   logic [8:0]          x_rem0;
   logic [8:0]          x_rem;
   logic [ROW_BITS-1:0] toggle;

   // x mod columns by reciprocal, quotient may be one short
   assign x_prod = 25'(x_position) * 25'(COL_RECIP);
   assign x_quo  = x_prod[24:RECIP_SH];
   assign x_rem0 = 9'(x_position) - 9'(x_quo * 9'(SCREEN_COLUMNS));
   assign x_rem  = (x_rem0 >= 9'(SCREEN_COLUMNS)) ? x_rem0 - 9'(SCREEN_COLUMNS) : x_rem0;

   always_comb begin
      logic [CW-1:0]    col;
      logic [POS_W-1:0] pos;
      toggle = '0;
      for (int k = 0; k < SPRITE_W; k++) begin
         col = CW'(x_rem) + CW'(k);
         if (col >= CW'(SCREEN_COLUMNS)) begin
            col = col - CW'(SCREEN_COLUMNS);
         end
         pos = POS_W'(ROW_BITS - 1 - int'(col));
         if (pixel_bits[SPRITE_W-1-k]) begin
            toggle[pos] = 1'b1;
         end
      end
   end

   assign word_new = word_old ^ toggle;
   assign hit      = |(word_old & toggle);

endmodule

`default_nettype wire

[sv/sprite_xor_framebuffer_draw_unit.sv]
// top level of the sprite xor framebuffer draw unit
//
// Keeps a monochrome framebuffer of SCREEN_ROWS words of 64 bits, one word
// per row, bit 63 holding column 0. A request is taken at a clock edge where
// start is high and busy is low. A draw request xors one sprite byte into
// row (y_position + row_offset) mod SCREEN_ROWS starting at column
// x_position mod SCREEN_COLUMNS, wrapping per pixel, and updates the
// collision flag (cleared by first_row, set when a lit pixel turns off).
// A read request returns one framebuffer row, or zero beyond the screen.
// Every request gives exactly one response: rsp_valid is high for one cycle
// with rsp_data, and the receiver cannot hold it off.
// Timing: the row word is read from the frame memory at the accept edge,
// modified and written back at the next edge, which also registers the
// response. Busy is high for that one cycle, so a new request is not taken
// until the last one is written back, and the response shows in the cycle
// after busy. The read-modify-write of the single memory port pair sets this order.
// Reset clears the collision flag and one valid bit per row in flip-flops;
// a row whose valid bit is clear reads as all zero, so no clearing pass.

`default_nettype none

module sprite_xor_framebuffer_draw_unit #(
   parameter int SCREEN_COLUMNS = sxfd_pkg::DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = sxfd_pkg::DEF_SCREEN_ROWS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  sxfd_pkg::sxfd_req_type req_data,
   output logic                   busy,
   output logic                   rsp_valid,
   output sxfd_pkg::sxfd_rsp_type rsp_data
);
   import sxfd_pkg::*;

   localparam int ROW_AW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
   localparam logic [16:0] ROW_RECIP = 17'((1 << RECIP_SH) / SCREEN_ROWS);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   sxfd_req_type        req_ff;
   logic [ROW_AW-1:0]   row_ff;
   logic                oob_ff;
   logic [ROW_BITS-1:0] rd_ff;
   logic [SCREEN_ROWS-1:0] valid_ff, valid_in;
   logic                flag_ff, flag_in;
   logic                rsp_valid_ff, rsp_valid_in;
   sxfd_rsp_type        rsp_ff, rsp_in;

   logic [ROW_BITS-1:0] mem [SCREEN_ROWS];

   logic                accept;
   logic [8:0]          row_sum;
   logic [25:0]         row_prod;
   logic [9:0]          row_quo;
   logic [9:0]          row_rem0;
   logic [9:0]          row_rem;
   logic [ROW_AW-1:0]   rd_addr;
   logic                rd_oob;
   logic [ROW_BITS-1:0] word_old;
   logic [ROW_BITS-1:0] word_new;
   logic                hit;
   logic                wr_en;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff == ST_EXEC);

   // draw row: (y + offset) mod rows by reciprocal, quotient may be one short
   assign row_sum  = 9'(req_data.y_position) + 9'(req_data.row_offset);
   assign row_prod = 26'(row_sum) * 26'(ROW_RECIP);
   assign row_quo  = row_prod[25:RECIP_SH];
   assign row_rem0 = 10'(row_sum) - 10'(row_quo * 10'(SCREEN_ROWS));
   assign row_rem  = (row_rem0 >= 10'(SCREEN_ROWS)) ? row_rem0 - 10'(SCREEN_ROWS) : row_rem0;

   assign rd_oob  = (req_data.kind == KIND_READ) &&
                    (7'(req_data.read_row) >= 7'(SCREEN_ROWS));
   assign rd_addr = (req_data.kind == KIND_READ) ? (rd_oob ? '0 : ROW_AW'(req_data.read_row))
                                                 : ROW_AW'(row_rem);

   assign word_old = valid_ff[row_ff] ? rd_ff : '0;

   sxfd_row_xor #(
      .SCREEN_COLUMNS(SCREEN_COLUMNS)
   ) u_row_xor (
      .x_position (req_ff.x_position),
      .pixel_bits (req_ff.pixel_bits),
      .word_old   (word_old),
      .word_new   (word_new),
      .hit        (hit)
   );

   assign wr_en = (state_ff == ST_EXEC) && (req_ff.kind == KIND_DRAW);

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      flag_in      = flag_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (req_ff.kind == KIND_DRAW) begin
               flag_in              = (flag_ff && !req_ff.first_row) || hit;
               valid_in[row_ff]     = 1'b1;
               rsp_in.collision     = (flag_ff && !req_ff.first_row) || hit;
               rsp_in.sprite_done   = req_ff.last_row;
               rsp_in.row_data      = '0;
            end else begin
               rsp_in.collision     = flag_ff;
               rsp_in.sprite_done   = 1'b0;
               rsp_in.row_data      = oob_ff ? '0 : word_old;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         req_ff <= req_data;
         row_ff <= rd_addr;
         oob_ff <= rd_oob;
      end
   end

   // frame memory, synchronous read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[row_ff] <= word_new;
      end
      if (accept) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without going busy");

   a_one_response: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && !busy))
      else $error("busy cycle not followed by a response");

   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request in work");

   a_draw_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.sprite_done) |-> (rsp_data.row_data == '0))
      else $error("draw response carries row data");

endmodule

`default_nettype wire

[tb/sprite_xor_framebuffer_draw_unit_tb.sv]
// testbench of the sprite xor framebuffer draw unit: directed and random sprite draws and row reads
`timescale 1ns / 100ps

module sprite_xor_framebuffer_draw_unit_tb;
   import sxfd_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 12;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 600;
   localparam int DRAIN_CYCLES = 4;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   sxfd_req_type req_data = '0;
   logic         busy;
   logic         rsp_valid;
   sxfd_rsp_type rsp_data;

   logic [ROW_BITS-1:0] frame_image [DEF_SCREEN_ROWS];
   logic                collision_state;
   sxfd_rsp_type        pending_results [$];
   sxfd_rsp_type        wanted_rsp;

   int error_count     = 0;
   int draw_count      = 0;
   int read_count      = 0;
   int sprite_count    = 0;
   int collision_count = 0;
   int idle_cycles     = 0;
   int burst_left      = 0;

   sprite_xor_framebuffer_draw_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // xor one sprite row into the frame image, or fetch one row
   function automatic sxfd_rsp_type apply_request(input sxfd_req_type r);
      sxfd_rsp_type        res;
      int                  row;
      int                  col;
      logic [ROW_BITS-1:0] word;
      res = '0;
      if (r.kind == KIND_DRAW) begin
         if (r.first_row) begin
            collision_state = 1'b0;
         end
         row  = (int'(r.y_position) + int'(r.row_offset)) % DEF_SCREEN_ROWS;
         word = frame_image[row];
         for (int k = 0; k < SPRITE_W; k++) begin
            if (r.pixel_bits[SPRITE_W-1-k]) begin
               col = (int'(r.x_position) + k) % DEF_SCREEN_COLUMNS;
               if (word[ROW_BITS-1-col]) begin
                  collision_state = 1'b1;
               end
               word[ROW_BITS-1-col] = ~word[ROW_BITS-1-col];
            end
         end
         frame_image[row] = word;
         res.collision    = collision_state;
         res.sprite_done  = r.last_row;
      end else begin
         res.collision = collision_state;
         if (int'(r.read_row) < DEF_SCREEN_ROWS) begin
            res.row_data = frame_image[r.read_row];
         end
      end
      return res;
   endfunction

   function automatic sxfd_req_type random_req();
      sxfd_req_type r;
      r.kind        = 1'($urandom_range(0, 1));
      r.x_position  = 8'($urandom_range(0, 255));
      r.y_position  = 8'($urandom_range(0, 255));
      r.row_offset  = 4'($urandom_range(0, 15));
      r.pixel_bits  = 8'($urandom_range(0, 255));
      r.first_row   = 1'($urandom_range(0, 1));
      r.last_row    = 1'($urandom_range(0, 1));
      r.read_row    = 5'($urandom_range(0, 31));
      return r;
   endfunction

   function automatic sxfd_req_type draw_req(input logic [7:0] x, input logic [7:0] y,
                                             input logic [3:0] offset,
                                             input logic [7:0] pixels,
                                             input logic first, input logic last);
      sxfd_req_type r;
      r             = '0;
      r.kind        = KIND_DRAW;
      r.x_position  = x;
      r.y_position  = y;
      r.row_offset  = offset;
      r.pixel_bits  = pixels;
      r.first_row   = first;
      r.last_row    = last;
      return r;
   endfunction

   function automatic sxfd_req_type read_req(input logic [4:0] row);
      sxfd_req_type r;
      r          = '0;
      r.kind     = KIND_READ;
      r.read_row = row;
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance with start high
   task automatic send_req(input sxfd_req_type r);
      req_data = r;
      start    = 1'b1;
      while (busy) begin
         @(negedge clock);
      end
      @(posedge clock);
      pending_results.push_back(apply_request(r));
      if (r.kind == KIND_DRAW) begin
         draw_count++;
      end else begin
         read_count++;
      end
      @(negedge clock);
   endtask

   task automatic paced_send(input sxfd_req_type r);
      if (burst_left == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      send_req(r);
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (pending_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic test_cleared_frame();
      send_req(read_req(5'd0));
      send_req(read_req(5'd31));
      send_req(read_req(5'd17));
   endtask

   task automatic test_directed_draws();
      // full byte at origin, then overlap for a collision
      send_req(draw_req(8'd0, 8'd0, 4'd0, 8'hFF, 1'b1, 1'b1));
      send_req(read_req(5'd0));
      send_req(draw_req(8'd0, 8'd0, 4'd0, 8'h81, 1'b1, 1'b1));
      // largest origin and offset, wrapping in both directions
      send_req(draw_req(8'd255, 8'd255, 4'd15, 8'hAA, 1'b1, 1'b0));
      send_req(draw_req(8'd255, 8'd255, 4'd15, 8'h55, 1'b0, 1'b1));
      send_req(read_req(5'd14));
      // horizontal wrap across the right edge
      send_req(draw_req(8'd60, 8'd31, 4'd1, 8'hFF, 1'b1, 1'b1));
      send_req(read_req(5'd0));
      // empty byte with first mark clears the flag
      send_req(draw_req(8'd7, 8'd3, 4'd2, 8'h00, 1'b1, 1'b0));
      // flag carried into a row without first mark
      send_req(draw_req(8'd0, 8'd0, 4'd0, 8'h01, 1'b1, 1'b0));
      send_req(draw_req(8'd0, 8'd0, 4'd0, 8'h01, 1'b1, 1'b1));
      send_req(draw_req(8'd9, 8'd9, 4'd0, 8'h00, 1'b0, 1'b1));
      send_req(read_req(5'd0));
      // origin wrap by two full screens
      send_req(draw_req(8'd128, 8'd64, 4'd0, 8'h80, 1'b1, 1'b1));
      send_req(read_req(5'd0));
      send_req(read_req(5'd31));
      sprite_count += 8;
      wait_drained();
   endtask

   task automatic test_random_sprites();
      sxfd_req_type r;
      int           rows;
      int           sent;
      int           pick;
      int           next_pause;
      logic [7:0]   x0;
      logic [7:0]   y0;
      sent       = 0;
      next_pause = 150;
      burst_left = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            rows = $urandom_range(1, 16);
            if ($urandom_range(0, 2) == 0) begin
               x0 = 8'($urandom_range(0, 15));
               y0 = 8'($urandom_range(0, 7));
            end else begin
               x0 = 8'($urandom_range(0, 255));
               y0 = 8'($urandom_range(0, 255));
            end
            for (int i = 0; i < rows; i++) begin
               r             = random_req();
               r.kind        = KIND_DRAW;
               r.x_position  = x0;
               r.y_position  = y0;
               r.row_offset  = 4'(i);
               r.first_row   = (i == 0);
               r.last_row    = (i == rows - 1);
               paced_send(r);
               sent++;
            end
            sprite_count++;
         end else if (pick < 85) begin
            r      = random_req();
            r.kind = KIND_READ;
            paced_send(r);
            sent++;
         end else begin
            paced_send(random_req());
            sent++;
         end
         if (sent >= next_pause) begin
            wait_drained();
            next_pause += 150;
         end
      end
      wait_drained();
   endtask

   task automatic test_final_readback();
      for (int i = 0; i < DEF_SCREEN_ROWS; i++) begin
         send_req(read_req(5'(i)));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            wanted_rsp = pending_results.pop_front();
            if (rsp_data.collision) begin
               collision_count++;
            end
            if (rsp_data.collision !== wanted_rsp.collision) begin
               $error("collision expected %0d got %0d",
                      wanted_rsp.collision, rsp_data.collision);
               error_count++;
            end
            if (rsp_data.sprite_done !== wanted_rsp.sprite_done) begin
               $error("sprite_done expected %0d got %0d",
                      wanted_rsp.sprite_done, rsp_data.sprite_done);
               error_count++;
            end
            if (rsp_data.row_data !== wanted_rsp.row_data) begin
               $error("row_data expected %h got %h",
                      wanted_rsp.row_data, rsp_data.row_data);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding",
                  pending_results.size());
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      foreach (frame_image[i]) begin
         frame_image[i] = '0;
      end
      collision_state = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_cleared_frame();
      test_directed_draws();
      test_random_sprites();
      test_final_readback();
      wait_drained();
      $display("ran %0d draw rows in about %0d sprites and %0d row reads",
               draw_count, sprite_count, read_count);
      $display("%0d responses carried the collision flag, frame read back in full",
               collision_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/sxfd_pkg.sv
sv/sxfd_row_xor.sv
sv/sprite_xor_framebuffer_draw_unit.sv
tb/sprite_xor_framebuffer_draw_unit_tb.sv
